@@ src/cpsd_pkg.sv @@
package cpsd_pkg;

  // Parse position within one post of a column.
  typedef enum logic [2:0] {
    PH_OFFSET,
    PH_LENGTH,
    PH_PAD_BEFORE,
    PH_PIXELS,
    PH_PAD_AFTER,
    PH_DONE
  } phase_t;

  localparam int unsigned ROW_W = 11;     // signed row, column top plus offsets
  localparam int unsigned REM_W = 8;
  localparam int unsigned X_W = 9;
  localparam int unsigned Y_W = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADDR_OUT_W = 16;
  localparam int unsigned MASK_W = 4;
  localparam int unsigned ROW_IDX_W = 10;  // on-screen row, below 1024

  localparam logic [BYTE_W-1:0] TERMINATOR = 8'hff;
  localparam logic [MASK_W-1:0] LINEAR_MASK = 4'hf;
  localparam logic [MASK_W-1:0] PLANE_ONE = 4'h1;

  // Event handed from the parse stage to the address stage.
  typedef struct packed {
    logic is_write;
    logic is_end;
    logic [ROW_IDX_W-1:0] row;
    logic [X_W-1:0] x;
    logic [BYTE_W-1:0] pixel;
    logic planar;
  } event_t;

endpackage

@@ src/cpsd_ifs.sv @@
interface cpsd_in_if;
  logic valid;
  logic ready;
  logic [cpsd_pkg::BYTE_W-1:0] data_byte;
  logic column_start;
  logic [cpsd_pkg::X_W-1:0] column_x;
  logic signed [cpsd_pkg::Y_W-1:0] column_y;

  modport source (output valid, data_byte, column_start, column_x, column_y, input ready);
  modport sink (input valid, data_byte, column_start, column_x, column_y, output ready);
endinterface

interface cpsd_out_if;
  logic valid;
  logic ready;
  logic write_valid;
  logic [cpsd_pkg::ADDR_OUT_W-1:0] write_address;
  logic [cpsd_pkg::BYTE_W-1:0] pixel;
  logic [cpsd_pkg::MASK_W-1:0] plane_mask;
  logic column_end;

  modport source (output valid, write_valid, write_address, pixel, plane_mask, column_end,
                  input ready);
  modport sink (input valid, write_valid, write_address, pixel, plane_mask, column_end,
                output ready);
endinterface

interface cpsd_cfg_if;
  logic valid;
  logic ready;
  logic planar_mode;

  modport source (output valid, planar_mode, input ready);
  modport sink (input valid, planar_mode, output ready);
endinterface

@@ src/column_post_sprite_drawer.sv @@
// Channel  Dir  Word
// in       in   data_byte, column_start, column_x, column_y (one post-stream byte)
// out      out  write_valid, write_address, pixel, plane_mask, column_end
// cfg      in   planar_mode
//
// One byte is taken every cycle; a result passes the event and output registers.
// The parse stage updates the post state and registers an event; the address
// stage does one constant-stride multiply into the output register.
// Both stages hold when out is stalled, and in.ready follows that stall.
// Synchronous reset clears the parse state, valid flags and planar_mode.
module column_post_sprite_drawer #(
  parameter int unsigned SCREEN_WIDTH = 320,
  parameter int unsigned SCREEN_HEIGHT = 200
) (
  input  logic clk,
  input  logic rst,
  cpsd_in_if.sink in,
  cpsd_out_if.source out,
  cpsd_cfg_if.sink cfg
);

  localparam int unsigned MUL_W = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned ADDR_W = cpsd_pkg::ROW_IDX_W + MUL_W + 1;
  localparam logic [cpsd_pkg::ROW_W-1:0] HEIGHT_L = cpsd_pkg::ROW_W'(SCREEN_HEIGHT);

  logic planar_mode;

  cpsd_pkg::phase_t phase, phase_next;
  logic [cpsd_pkg::REM_W-1:0] remaining, remaining_next;
  logic signed [cpsd_pkg::ROW_W-1:0] row, row_next;
  logic [cpsd_pkg::X_W-1:0] held_x, held_x_next;
  logic signed [cpsd_pkg::Y_W-1:0] held_y, held_y_next;

  cpsd_pkg::event_t ev, ev_next;
  logic ev_valid;
  logic has_event;

  logic advance;
  logic accept;
  cpsd_pkg::phase_t cur_phase;

  assign advance = !out.valid || out.ready;
  assign in.ready = advance;
  assign accept = in.valid && advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      planar_mode <= 1'b0;
    end else if (cfg.valid) begin
      planar_mode <= cfg.planar_mode;
    end
  end

  // A column start restarts parsing on this very byte.
  assign cur_phase = in.column_start ? cpsd_pkg::PH_OFFSET : phase;
  assign held_x_next = in.column_start ? in.column_x : held_x;
  assign held_y_next = in.column_start ? in.column_y : held_y;

  // Next parse state.
  always_comb begin
    phase_next = cur_phase;
    remaining_next = remaining;
    row_next = row;
    unique case (cur_phase)
      cpsd_pkg::PH_OFFSET: begin
        if (in.data_byte == cpsd_pkg::TERMINATOR) begin
          phase_next = cpsd_pkg::PH_DONE;
        end else begin
          row_next = cpsd_pkg::ROW_W'(held_y_next)
                   + $signed({{(cpsd_pkg::ROW_W-cpsd_pkg::BYTE_W){1'b0}}, in.data_byte});
          phase_next = cpsd_pkg::PH_LENGTH;
        end
      end
      cpsd_pkg::PH_LENGTH: begin
        remaining_next = in.data_byte;
        phase_next = cpsd_pkg::PH_PAD_BEFORE;
      end
      cpsd_pkg::PH_PAD_BEFORE: begin
        phase_next = (remaining != '0) ? cpsd_pkg::PH_PIXELS : cpsd_pkg::PH_PAD_AFTER;
      end
      cpsd_pkg::PH_PIXELS: begin
        row_next = row + cpsd_pkg::ROW_W'(1);
        remaining_next = remaining - cpsd_pkg::REM_W'(1);
        if (remaining_next == '0) begin
          phase_next = cpsd_pkg::PH_PAD_AFTER;
        end
      end
      cpsd_pkg::PH_PAD_AFTER: phase_next = cpsd_pkg::PH_OFFSET;
      cpsd_pkg::PH_DONE: phase_next = cpsd_pkg::PH_DONE;
      default: phase_next = cpsd_pkg::PH_DONE;
    endcase
  end

  // Event produced by this byte, if any.
  always_comb begin
    ev_next.is_write = 1'b0;
    ev_next.is_end = 1'b0;
    ev_next.row = row[cpsd_pkg::ROW_IDX_W-1:0];
    ev_next.x = held_x_next;
    ev_next.pixel = in.data_byte;
    ev_next.planar = planar_mode;
    unique case (cur_phase)
      cpsd_pkg::PH_OFFSET: ev_next.is_end = (in.data_byte == cpsd_pkg::TERMINATOR);
      cpsd_pkg::PH_PIXELS: begin
        // Rows above or below the screen are dropped.
        ev_next.is_write = !row[cpsd_pkg::ROW_W-1]
                        && ($unsigned(row) < HEIGHT_L);
      end
      default: ev_next.is_write = 1'b0;
    endcase
  end

  assign has_event = ev_next.is_write || ev_next.is_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cpsd_pkg::PH_OFFSET;
      remaining <= '0;
      row <= '0;
      held_x <= '0;
      held_y <= '0;
    end else if (accept) begin
      phase <= phase_next;
      remaining <= remaining_next;
      row <= row_next;
      held_x <= held_x_next;
      held_y <= held_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (advance) begin
      ev_valid <= accept && has_event;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev <= ev_next;
    end
  end

  // Address stage.
  logic [MUL_W-1:0] stride;
  logic [cpsd_pkg::X_W-1:0] x_offset;
  logic [ADDR_W-1:0] addr_full;
  logic [cpsd_pkg::MASK_W-1:0] mask;

  assign stride = ev.planar ? MUL_W'(SCREEN_WIDTH / 4) : MUL_W'(SCREEN_WIDTH);
  assign x_offset = ev.planar ? (ev.x >> 2) : ev.x;
  assign addr_full = ADDR_W'(ev.row) * ADDR_W'(stride) + ADDR_W'(x_offset);
  assign mask = ev.planar ? (cpsd_pkg::PLANE_ONE << ev.x[1:0]) : cpsd_pkg::LINEAR_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (advance) begin
      out.valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out.write_valid <= ev.is_write;
      out.column_end <= ev.is_end;
      out.write_address <= ev.is_end ? '0 : cpsd_pkg::ADDR_OUT_W'(addr_full);
      out.pixel <= ev.is_end ? '0 : ev.pixel;
      out.plane_mask <= ev.is_end ? '0 : mask;
    end
  end

endmodule
